@@ hdl/mcmr_pkg.sv @@
// ---------------------------------------------------------------------------
// mcmr_pkg: shared types and constants of the MIDI channel message router
// Item layouts, configuration set, register indexes and MIDI status codes.
// ---------------------------------------------------------------------------
package mcmr_pkg;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_ENGINE_PRESENT   = 3'd0,
      REG_TARGET_MAP       = 3'd1,
      REG_REMAP_TABLE      = 3'd2,
      REG_LAYER_MASK       = 3'd3,
      REG_CC_ALLOW_A_LOW   = 3'd4,
      REG_CC_ALLOW_A_HIGH  = 3'd5,
      REG_CC_ALLOW_B_LOW   = 3'd6,
      REG_CC_ALLOW_B_HIGH  = 3'd7
   } reg_index_type;

   localparam int CSR_DATA_W = 64;

   // engine codes on the result channel
   localparam logic ENG_A = 1'b0;
   localparam logic ENG_B = 1'b1;

   // per-channel target codes
   localparam logic [1:0] TGT_A = 2'd1;
   localparam logic [1:0] TGT_B = 2'd2;

   // status high nibbles
   localparam logic [3:0] TYPE_SYSTEM   = 4'hF;
   localparam logic [3:0] TYPE_CTRL_CHG = 4'hB;
   localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
   localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;

   // reset values
   localparam logic [63:0] REMAP_RESET = 64'hFEDC_BA98_7654_3210;
   localparam logic [63:0] ALLOW_RESET = '1;

   typedef struct packed {
      logic [1:0]  engine_present;
      logic [31:0] target_map;
      logic [63:0] remap_table;
      logic [15:0] layer_mask;
      logic [63:0] allow_a_low;
      logic [63:0] allow_a_high;
      logic [63:0] allow_b_low;
      logic [63:0] allow_b_high;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data2;
      logic [7:0] data1;
      logic [7:0] status;
   } msg_type;

   // routing decision for one message: up to two results
   typedef struct packed {
      logic [1:0] count;
      logic       engine0;
      logic       engine1;
      logic [7:0] out_status;
   } route_type;

   typedef struct packed {
      logic       engine;
      logic       last;
      logic [7:0] out_data2;
      logic [7:0] out_data1;
      logic [7:0] out_status;
   } result_type;

endpackage

@@ hdl/mcmr_csr.sv @@
// ---------------------------------------------------------------------------
// mcmr_csr: configuration registers
// Eight write-only registers, loaded from the plain write port.
// ---------------------------------------------------------------------------
module mcmr_csr
   import mcmr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_ENGINE_PRESENT:  cfg_in.engine_present = csr_wdata[1:0];
            REG_TARGET_MAP:      cfg_in.target_map     = csr_wdata[31:0];
            REG_REMAP_TABLE:     cfg_in.remap_table    = csr_wdata;
            REG_LAYER_MASK:      cfg_in.layer_mask     = csr_wdata[15:0];
            REG_CC_ALLOW_A_LOW:  cfg_in.allow_a_low    = csr_wdata;
            REG_CC_ALLOW_A_HIGH: cfg_in.allow_a_high   = csr_wdata;
            REG_CC_ALLOW_B_LOW:  cfg_in.allow_b_low    = csr_wdata;
            REG_CC_ALLOW_B_HIGH: cfg_in.allow_b_high   = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.engine_present <= '0;
         cfg_ff.target_map     <= '0;
         cfg_ff.remap_table    <= REMAP_RESET;
         cfg_ff.layer_mask     <= '0;
         cfg_ff.allow_a_low    <= ALLOW_RESET;
         cfg_ff.allow_a_high   <= ALLOW_RESET;
         cfg_ff.allow_b_low    <= ALLOW_RESET;
         cfg_ff.allow_b_high   <= ALLOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/mcmr_route.sv @@
// ---------------------------------------------------------------------------
// mcmr_route: routing decision for one message
// Works out how many results a message makes, their engines in order and
// the output status byte, remapped except for system messages.
// ---------------------------------------------------------------------------
module mcmr_route
   import mcmr_pkg::*;
(
   input  msg_type   msg,
   input  cfg_type   cfg,
   output route_type route
);

   logic [3:0]  msg_kind;
   logic [3:0]  chan;
   logic [1:0]  tgt_code;
   logic        layered;
   logic        pres_a;
   logic        pres_b;
   logic        has_tgt;
   logic        tgt_eng;
   logic [6:0]  cc_num;
   logic [63:0] mask_a;
   logic [63:0] mask_b;
   logic        allow_a;
   logic        allow_b;
   logic        allow_tgt;
   logic        send_tgt;
   logic        send_a;
   logic        send_b;
   logic [7:0]  rmp_status;

   assign msg_kind = msg.status[7:4];
   assign chan     = msg.status[3:0];
   assign tgt_code = cfg.target_map[{chan, 1'b0} +: 2];
   assign layered  = cfg.layer_mask[chan];
   assign pres_a   = cfg.engine_present[0];
   assign pres_b   = cfg.engine_present[1];

   // target engine, only when it exists
   assign has_tgt = ((tgt_code == TGT_A) && pres_a) || ((tgt_code == TGT_B) && pres_b);
   assign tgt_eng = (tgt_code == TGT_B) ? ENG_B : ENG_A;

   // controller allow lookup, low seven bits of data1
   assign cc_num    = msg.data1[6:0];
   assign mask_a    = cc_num[6] ? cfg.allow_a_high : cfg.allow_a_low;
   assign mask_b    = cc_num[6] ? cfg.allow_b_high : cfg.allow_b_low;
   assign allow_a   = mask_a[cc_num[5:0]];
   assign allow_b   = mask_b[cc_num[5:0]];
   assign allow_tgt = (tgt_eng == ENG_B) ? allow_b : allow_a;

   // send slots: target first, then A, then B
   always_comb begin
      send_tgt   = 1'b0;
      send_a     = 1'b0;
      send_b     = 1'b0;
      rmp_status = {msg_kind, cfg.remap_table[{chan, 2'b00} +: 4]};
      priority if (msg_kind == TYPE_SYSTEM) begin
         send_a     = pres_a;
         send_b     = pres_b;
         rmp_status = msg.status;
      end else if (msg_kind == TYPE_CTRL_CHG) begin
         send_tgt = has_tgt && allow_tgt;
         send_a   = layered && !(has_tgt && (tgt_eng == ENG_A)) && pres_a && allow_a;
         send_b   = layered && !(has_tgt && (tgt_eng == ENG_B)) && pres_b && allow_b;
      end else if (layered && ((msg_kind == TYPE_NOTE_ON) || (msg_kind == TYPE_NOTE_OFF)))
      begin
         send_a = pres_a;
         send_b = pres_b;
      end else begin
         send_tgt = has_tgt;
      end
   end

   // compact the slots into at most two results
   assign route.out_status = rmp_status;
   assign route.count   = 2'({1'b0, send_tgt}) + 2'({1'b0, send_a}) + 2'({1'b0, send_b});
   assign route.engine0 = send_tgt ? tgt_eng : (send_a ? ENG_A : ENG_B);
   assign route.engine1 = (send_tgt && send_a) ? ENG_A : ENG_B;

endmodule

@@ hdl/midi_channel_message_router_core.sv @@
// ---------------------------------------------------------------------------
// midi_channel_message_router_core: MIDI short message router, two engines
// Input register, routing decision and one result register feeding the
// output stream; a message that needs two results holds the input stage
// until its second result is loaded.
// ---------------------------------------------------------------------------
//
//   channel  dir  tdata (low bit up)               tuser   tlast
//   req_     in   status, data1, data2 (24 bits)   -       -
//   rsp_     out  out_status, out_data1, out_data2 engine  last
//   csr_     in   write enable, index 0..7, 64-bit data
//
// The single result register on rsp_ takes one result at a time, so the
// two results of a message leave one after the other. Messages with no
// result leave the input stage without using it. An accepted message
// passes the input stage and the result register before rsp_tvalid
// rises. Reset is synchronous and empties both stages. A stall on rsp_
// holds the result register and, through req_tready, the input stage.
//
module midi_channel_message_router_core
   import mcmr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // message input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // status, data1, data2
   // routed results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // out_status, out_data1, out_data2
   output logic                  rsp_tuser,   // engine
   output logic                  rsp_tlast,
   // configuration
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   route_type  route;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       s1_phase_ff;
   logic       s1_phase_in;
   msg_type    s1_msg_ff;
   msg_type    s1_msg_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_item_ff;
   result_type rsp_item_in;

   logic       out_free;
   logic       final_res;
   logic       s1_done;
   logic       load;
   logic       req_take;

   mcmr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mcmr_route u_route (
      .msg   (s1_msg_ff),
      .cfg   (cfg),
      .route (route)
   );

   // handshake control
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign final_res  = s1_phase_ff || (route.count == 2'd1);
   assign load       = s1_valid_ff && (route.count != 2'd0) && out_free;
   assign s1_done    = s1_valid_ff && ((route.count == 2'd0) || (out_free && final_res));
   assign req_tready = !s1_valid_ff || s1_done;
   assign req_take   = req_tvalid && req_tready;

   // input stage next values
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_phase_in = s1_phase_ff;
      s1_msg_in   = s1_msg_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_phase_in = 1'b0;
         s1_msg_in   = msg_type'(req_tdata);
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
         s1_phase_in = 1'b0;
      end else if (load) begin
         s1_phase_in = 1'b1;
      end
   end

   // result register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_item_in  = rsp_item_ff;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_item_in.engine      = s1_phase_ff ? route.engine1 : route.engine0;
         rsp_item_in.last        = final_res;
         rsp_item_in.out_status  = route.out_status;
         rsp_item_in.out_data1   = s1_msg_ff.data1;
         rsp_item_in.out_data2   = s1_msg_ff.data2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_phase_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_phase_ff  <= s1_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_msg_ff   <= s1_msg_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.out_data2, rsp_item_ff.out_data1, rsp_item_ff.out_status};
   assign rsp_tuser  = rsp_item_ff.engine;
   assign rsp_tlast  = rsp_item_ff.last;

   // second-result phase only exists with a message in the input stage
   a_phase_needs_item: assert property (@(posedge clock) disable iff (reset)
      s1_phase_ff |-> s1_valid_ff)
      else $error("second-result phase without a held message");

   // a non-final result leaves the input stage waiting for the second one
   a_first_then_second: assert property (@(posedge clock) disable iff (reset)
      (load && !final_res) |=> (s1_valid_ff && s1_phase_ff))
      else $error("first of two results sent but second not pending");

   // the two results of one message go to different engines
   a_distinct_engines: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (route.count == 2'd2)) |-> (route.engine0 != route.engine1))
      else $error("both results routed to the same engine");

   // an accepted message lands in the input stage
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (s1_valid_ff && !s1_phase_ff))
      else $error("accepted message not held in input stage");

endmodule
